// ----- hw/rtl/pwq_pkg.sv -----
// Shared types and constants for the priority wait queue.
`timescale 1ns / 1ps
package pwq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int HANDLE_W = 16;
   localparam int TASK_W   = 8;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;

   localparam logic [PRIO_W-1:0] PRIO_LIMIT_RST = 8'd255;

   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

   localparam logic [STATUS_W-1:0] ST_PUT_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PUT_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_GOT      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [TASK_W-1:0]   client_task;
      logic [PRIO_W-1:0]   prio;
   } entry_type;

endpackage

// ----- hw/rtl/pwq_if.sv -----
// Request and response channel interfaces of the priority wait queue.
`timescale 1ns / 1ps
interface pwq_req_if;
   import pwq_pkg::*;
   logic                valid;
   logic                ready;
   logic                command;
   logic [HANDLE_W-1:0] request_handle;
   logic [TASK_W-1:0]   client_task;
   logic [PRIO_W-1:0]   priority_req;

   modport source (output valid, command, request_handle, client_task, priority_req,
                   input ready);
   modport sink   (input valid, command, request_handle, client_task, priority_req,
                   output ready);
endinterface

interface pwq_rsp_if;
   import pwq_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] out_handle;
   logic [TASK_W-1:0]   out_task;
   logic [PRIO_W-1:0]   out_priority;
   logic                wake_server;

   modport source (output valid, status, out_handle, out_task, out_priority, wake_server,
                   input ready);
   modport sink   (input valid, status, out_handle, out_task, out_priority, wake_server,
                   output ready);
endinterface

// ----- hw/rtl/priority_wait_queue_unit.sv -----
// Priority wait queue: arrival-ordered entry memory with linear-scan get.
//
//   channel    direction  contents
//   req_chan   in         command, request_handle, client_task, priority_req
//   rsp_chan   out        status, out_handle, out_task, out_priority, wake_server
//   csr_*      in         priority_limit write (csr_wr_en, csr_wr_data)
//
// Put: result beat registered at accept.
// Get: scan for the lowest priority below the limit, then shift later entries down to
//   close the gap and respond, bounded by the single read port of the entry memory.
// Reset clears the state, entry count, limit and response valid; the memory is not cleared.
// A new beat is taken only when idle and the result register is free or draining.
`timescale 1ns / 1ps
module priority_wait_queue_unit #(
   parameter int QUEUE_DEPTH = pwq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   pwq_req_if.sink                   req_chan,
   pwq_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [pwq_pkg::PRIO_W-1:0] csr_wr_data
);
   import pwq_pkg::*;

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   entry_type mem [QUEUE_DEPTH];

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]    chk_idx_ff, chk_idx_in;
   logic [PRIO_W-1:0]   best_ff, best_in;
   logic [IDX_W-1:0]    pick_ff, pick_in;
   entry_type           word_ff, word_in;
   logic                found_ff, found_in;
   logic [PRIO_W-1:0]   limit_ff, limit_in;
   entry_type           rd_data_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [TASK_W-1:0]   rsp_task_ff, rsp_task_in;
   logic [PRIO_W-1:0]   rsp_prio_ff, rsp_prio_in;
   logic                rsp_wake_ff, rsp_wake_in;

   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   entry_type           mem_wdata;
   logic [IDX_W-1:0]    mem_raddr;

   logic                out_free;
   logic                req_fire;
   logic                scan_hit;
   logic                chk_last;
   logic [IDX_W-1:0]    pick_nx;
   logic                found_nx;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign mem_raddr = issue_ff[IDX_W-1:0];

   assign scan_hit = chk_vld_ff && (rd_data_ff.prio < best_ff);
   assign chk_last = chk_vld_ff && (CNT_W'(chk_idx_ff) == count_ff - CNT_W'(1));
   assign pick_nx  = scan_hit ? chk_idx_ff : pick_ff;
   assign found_nx = scan_hit || found_ff;

   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.out_handle   = rsp_handle_ff;
   assign rsp_chan.out_task     = rsp_task_ff;
   assign rsp_chan.out_priority = rsp_prio_ff;
   assign rsp_chan.wake_server  = rsp_wake_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      best_in       = best_ff;
      pick_in       = pick_ff;
      word_in       = word_ff;
      found_in      = found_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_wake_in   = rsp_wake_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_chan.command == CMD_PUT) begin
                  rsp_valid_in  = 1'b1;
                  rsp_handle_in = '0;
                  rsp_task_in   = '0;
                  rsp_prio_in   = '0;
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     rsp_status_in = ST_PUT_FULL;
                     rsp_wake_in   = 1'b0;
                  end else begin
                     mem_we        = 1'b1;
                     mem_waddr     = count_ff[IDX_W-1:0];
                     mem_wdata     = '{handle: req_chan.request_handle,
                                       client_task: req_chan.client_task,
                                       prio: req_chan.priority_req};
                     count_in      = count_ff + CNT_W'(1);
                     rsp_status_in = ST_PUT_OK;
                     rsp_wake_in   = 1'b1;
                  end
               end else begin
                  best_in  = limit_ff;
                  found_in = 1'b0;
                  pick_in  = '0;
                  word_in  = '0;
                  issue_in = '0;
                  state_in = (count_ff == '0) ? S_DONE : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff < count_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + CNT_W'(1);
            end
            if (scan_hit) begin
               best_in  = rd_data_ff.prio;
               pick_in  = chk_idx_ff;
               word_in  = rd_data_ff;
               found_in = 1'b1;
            end
            if (chk_last) begin
               if (found_nx && (CNT_W'(pick_nx) != count_ff - CNT_W'(1))) begin
                  issue_in = CNT_W'(pick_nx) + CNT_W'(1);
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT: begin
            // move each later entry down by one slot
            if (issue_ff < count_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + CNT_W'(1);
            end
            if (chk_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = chk_idx_ff - IDX_W'(1);
               mem_wdata = rd_data_ff;
            end
            if (chk_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_wake_in  = 1'b0;
               if (found_ff) begin
                  rsp_status_in = ST_GOT;
                  rsp_handle_in = word_ff.handle;
                  rsp_task_in   = word_ff.client_task;
                  rsp_prio_in   = word_ff.prio;
                  count_in      = count_ff - CNT_W'(1);
               end else begin
                  rsp_status_in = ST_NONE;
                  rsp_handle_in = '0;
                  rsp_task_in   = '0;
                  rsp_prio_in   = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         limit_ff     <= PRIO_LIMIT_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_vld_ff   <= chk_vld_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff      <= issue_in;
      chk_idx_ff    <= chk_idx_in;
      best_ff       <= best_in;
      pick_ff       <= pick_in;
      word_ff       <= word_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_wake_ff   <= rsp_wake_in;
   end

endmodule

// ----- bench/pwq_result_checker.sv -----
// Beat monitor, queue predictor and response comparator for the priority wait queue.
`timescale 1ns / 1ps
module pwq_result_checker
   import pwq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   pwq_req_if                req_chan,
   pwq_rsp_if                rsp_chan,
   input  logic              csr_wr_en,
   input  logic [PRIO_W-1:0] csr_wr_data,
   output int                mismatch_count,
   output int                pending_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [HANDLE_W-1:0] handle;
      logic [TASK_W-1:0]   client_task;
      logic [PRIO_W-1:0]   prio;
      logic                wake;
   } rsp_beat_type;

   entry_type         waiting[$];
   rsp_beat_type      due_rsp[$];
   logic [PRIO_W-1:0] limit_q = PRIO_LIMIT_RST;
   int                err_total = 0;

   // arrival-ordered store; get takes lowest prio below limit, oldest on tie
   function automatic rsp_beat_type serve_request(input logic cmd, input entry_type ent);
      rsp_beat_type      r;
      int                pick;
      logic [PRIO_W-1:0] best;
      r.status      = ST_PUT_OK;
      r.handle      = '0;
      r.client_task = '0;
      r.prio        = '0;
      r.wake        = 1'b0;
      if (cmd == CMD_PUT) begin
         if (waiting.size() >= QUEUE_DEPTH_DEF) begin
            r.status = ST_PUT_FULL;
         end else begin
            waiting.push_back(ent);
            r.wake = 1'b1;
         end
      end else begin
         best = limit_q;
         pick = -1;
         foreach (waiting[i]) begin
            if (waiting[i].prio < best) begin
               best = waiting[i].prio;
               pick = i;
            end
         end
         if (pick < 0) begin
            r.status = ST_NONE;
         end else begin
            r.status      = ST_GOT;
            r.handle      = waiting[pick].handle;
            r.client_task = waiting[pick].client_task;
            r.prio        = waiting[pick].prio;
            waiting.delete(pick);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      entry_type    ent;
      if (reset) begin
         waiting.delete();
         due_rsp.delete();
         limit_q = PRIO_LIMIT_RST;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status      = rsp_chan.status;
            got.handle      = rsp_chan.out_handle;
            got.client_task = rsp_chan.out_task;
            got.prio        = rsp_chan.out_priority;
            got.wake        = rsp_chan.wake_server;
            if (due_rsp.size() == 0) begin
               err_total++;
               $display("%0t: unexpected beat: expected none,", $time,
                        " actual st %0d h %h t %h p %h w %b",
                        got.status, got.handle, got.client_task, got.prio, got.wake);
            end else begin
               want = due_rsp.pop_front();
               if (got !== want) begin
                  err_total++;
                  $display("%0t: mismatch: expected st %0d h %h t %h p %h w %b,",
                           $time, want.status, want.handle, want.client_task, want.prio,
                           want.wake, " actual st %0d h %h t %h p %h w %b",
                           got.status, got.handle, got.client_task, got.prio, got.wake);
               end
            end
         end
         if (csr_wr_en) begin
            limit_q = csr_wr_data;
         end
         if (req_chan.valid && req_chan.ready) begin
            ent.handle      = req_chan.request_handle;
            ent.client_task = req_chan.client_task;
            ent.prio        = req_chan.priority_req;
            due_rsp.push_back(serve_request(req_chan.command, ent));
         end
      end
      mismatch_count <= err_total;
      pending_count  <= due_rsp.size();
   end

endmodule

// ----- bench/priority_wait_queue_unit_tb.sv -----
// Top level testbench: clock, reset, request and limit stimulus, verdict.
`timescale 1ns / 1ps
module priority_wait_queue_unit_tb;
   import pwq_pkg::*;

   localparam int QUIET_LIMIT = 5000;
   localparam int PHASE_BEATS = 190;
   localparam int DRAIN_WAIT  = 2 * QUEUE_DEPTH_DEF + 8;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en;
   logic [PRIO_W-1:0] csr_wr_data;
   logic              calm = 1'b0;
   int                mismatch_count;
   int                pending_count;
   int                quiet_cycles = 0;

   pwq_req_if req_bus ();
   pwq_rsp_if rsp_bus ();

   priority_wait_queue_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pwq_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(99) >= 22);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("priority_wait_queue_unit_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(input logic cmd, input logic [HANDLE_W-1:0] handle,
                            input logic [TASK_W-1:0] client, input logic [PRIO_W-1:0] prio);
      if (!calm && $urandom_range(99) < 22) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.command        <= cmd;
      req_bus.request_handle <= handle;
      req_bus.client_task    <= client;
      req_bus.priority_req   <= prio;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [PRIO_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_beat(input int put_pct, input bit wide_prio);
      logic [PRIO_W-1:0] prio;
      prio = wide_prio ? PRIO_W'($urandom_range(255)) : PRIO_W'($urandom_range(15));
      if ($urandom_range(99) < put_pct) begin
         send_beat(CMD_PUT, HANDLE_W'($urandom_range(16'hFFFF)),
                   TASK_W'($urandom_range(255)), prio);
      end else begin
         send_beat(CMD_GET, HANDLE_W'($urandom_range(16'hFFFF)),
                   TASK_W'($urandom_range(255)), PRIO_W'($urandom_range(255)));
      end
   endtask

   initial begin
      logic [PRIO_W-1:0] limit_plan [8];
      int                put_plan   [8];
      logic [PRIO_W-1:0] prio;
      limit_plan = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd254, 8'd16, 8'd8, 8'd255};
      put_plan   = '{65, 70, 50, 45, 55, 35, 50, 40};
      req_bus.valid          <= 1'b0;
      req_bus.command        <= CMD_PUT;
      req_bus.request_handle <= '0;
      req_bus.client_task    <= '0;
      req_bus.priority_req   <= '0;
      csr_wr_en              <= 1'b0;
      csr_wr_data            <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty get, fill with extremes and ties, overflow, limit corners
      send_beat(CMD_GET, 16'hFFFF, 8'hFF, 8'hFF);
      for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
         if (i == 0) begin
            send_beat(CMD_PUT, 16'hFFFF, 8'hFF, 8'hFF);
         end else if (i == 1) begin
            send_beat(CMD_PUT, 16'h0000, 8'h00, 8'h00);
         end else begin
            prio = (i % 3 == 0) ? 8'd9 : PRIO_W'(40 + i);
            send_beat(CMD_PUT, HANDLE_W'($urandom_range(16'hFFFF)),
                      TASK_W'($urandom_range(255)), prio);
         end
      end
      send_beat(CMD_PUT, 16'hA5A5, 8'h5A, 8'd1);
      repeat (3) send_beat(CMD_GET, 16'h0000, 8'h00, 8'h00);
      write_limit(8'd0);
      send_beat(CMD_GET, 16'h1234, 8'h56, 8'h78);
      write_limit(8'd9);
      send_beat(CMD_GET, 16'h0000, 8'h00, 8'h00);

      for (int ph = 0; ph < 8; ph++) begin
         write_limit((ph == 6) ? PRIO_W'($urandom_range(255)) : limit_plan[ph]);
         calm <= (ph == 3);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            random_beat(put_plan[ph], (ph % 2 == 1) || ($urandom_range(9) == 0));
         end
         calm <= 1'b0;
      end

      settle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("priority_wait_queue_unit_tb: clean");
      end else begin
         $display("priority_wait_queue_unit_tb: errors");
      end
      $finish;
   end

endmodule
